// ===== hdl/binary_to_ascii_number_formatter_macros.svh =====
// Assertion macros used by the checker file.
`ifndef BINARY_TO_ASCII_NUMBER_FORMATTER_MACROS_SVH
`define BINARY_TO_ASCII_NUMBER_FORMATTER_MACROS_SVH

// Concurrent check, off while reset is asserted.
`define B2A_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define B2A_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/b2a_pkg.sv =====
package b2a_pkg;

  localparam int DIGITS        = 20;
  localparam int DIGIT_W       = 4;
  localparam int BCD_W         = DIGITS * DIGIT_W;
  localparam int VALUE_W       = 64;
  localparam int BITS_PER_STEP = 4;
  localparam int DABBLE_STAGES = VALUE_W / BITS_PER_STEP;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [1:0] {
    MODE_UDEC = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  // In hex mode bcd holds the raw value as nibbles and is left alone.
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic               neg;
    logic               hex;
    logic [1:0]         hex_width;
  } stage_t;

  // Shift-add-3 over BITS_PER_STEP input bits.
  function automatic stage_t dabble_step(stage_t s);
    stage_t r;
    logic [DIGIT_W-1:0] d;
    r = s;
    if (!s.hex) begin
      for (int b = 0; b < BITS_PER_STEP; b++) begin
        for (int j = 0; j < DIGITS; j++) begin
          d = r.bcd[j*DIGIT_W +: DIGIT_W];
          if (d >= 4'd5) begin
            r.bcd[j*DIGIT_W +: DIGIT_W] = d + 4'd3;
          end
        end
        r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
        r.bin = {r.bin[VALUE_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/b2a_dabble_stage.sv =====
module b2a_dabble_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  b2a_pkg::stage_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output b2a_pkg::stage_t data_o,
  input  logic            ready_i
);
  import b2a_pkg::*;

  logic   valid_q;
  stage_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= dabble_step(data_i);
    end
  end

endmodule

// ===== hdl/binary_to_ascii_number_formatter.sv =====
// Formats a 64-bit value as ASCII text, one character per output transfer,
// most significant first, tlast on the final character. tuser selects
// unsigned decimal, signed decimal or hex (mode 3 is dropped). Decimal runs
// through a 16-stage shift-add-3 pipeline, four value bits per stage; a
// number passes the input register, the dabble stages, the length register
// and the output register, and input transfers may follow every cycle until
// the pipeline fills. The character serializer at the end sets the rate: it
// loads a number, then sends its characters while the output is not stalled
// (up to 20 for decimal, 2/4/8/16 for hex), and only then takes the next.
module binary_to_ascii_number_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value
  input  logic [3:0]  s_axis_tuser,   // mode[1:0], hex_width[3:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // character
  output logic        m_axis_tlast
);
  import b2a_pkg::*;

  localparam int NumStages = DABBLE_STAGES;

  // Input stage: form the magnitude.
  logic   s0_valid_q;
  stage_t s0_q, s0_d;
  mode_e  mode;

  logic   [NumStages:0] pipe_valid;
  logic   [NumStages:0] pipe_ready;
  stage_t               pipe_data [NumStages+1];

  assign mode          = mode_e'(s_axis_tuser[1:0]);
  assign s_axis_tready = !s0_valid_q || pipe_ready[0];

  always_comb begin
    s0_d           = '0;
    s0_d.hex       = (mode == MODE_HEX);
    s0_d.neg       = (mode == MODE_SDEC) && s_axis_tdata[63];
    s0_d.hex_width = s_axis_tuser[3:2];
    if (s0_d.hex) begin
      s0_d.bcd = {{(BCD_W-VALUE_W){1'b0}}, s_axis_tdata};
    end else if (s0_d.neg) begin
      s0_d.bin = ~s_axis_tdata + 64'd1;
    end else begin
      s0_d.bin = s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid_q <= s_axis_tvalid && (mode != MODE_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s0_q <= s0_d;
    end
  end

  assign pipe_valid[0] = s0_valid_q;
  assign pipe_data[0]  = s0_q;

  for (genvar i = 0; i < NumStages; i++) begin : g_dabble
    b2a_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pipe_valid[i]),
      .data_i  (pipe_data[i]),
      .ready_o (pipe_ready[i]),
      .valid_o (pipe_valid[i+1]),
      .data_o  (pipe_data[i+1]),
      .ready_i (pipe_ready[i+1])
    );
  end

  // Length stage: find the first digit to print.
  logic             len_valid_q;
  logic             len_ready;
  logic [BCD_W-1:0] len_digits_q;
  logic [4:0]       len_top_q, len_top_d;
  logic             len_neg_q;
  stage_t           fin;
  logic             ser_ready;

  assign fin                   = pipe_data[NumStages];
  assign len_ready             = !len_valid_q || ser_ready;
  assign pipe_ready[NumStages] = len_ready;

  always_comb begin
    len_top_d = '0;
    if (fin.hex) begin
      len_top_d = (5'd2 << fin.hex_width) - 5'd1;
    end else begin
      for (int j = 1; j < DIGITS; j++) begin
        if (fin.bcd[j*DIGIT_W +: DIGIT_W] != '0) begin
          len_top_d = 5'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_valid_q <= 1'b0;
    end else if (len_ready) begin
      len_valid_q <= pipe_valid[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_ready && pipe_valid[NumStages]) begin
      len_digits_q <= fin.bcd;
      len_top_q    <= len_top_d;
      len_neg_q    <= fin.neg;
    end
  end

  // Serializer with registered output.
  logic             busy_q;
  logic             sign_q;
  logic [4:0]       idx_q;
  logic [BCD_W-1:0] digits_q;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;
  logic             adv;

  assign ser_ready     = !busy_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sign_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= busy_q;
      end
      if (!busy_q) begin
        if (len_valid_q) begin
          busy_q <= 1'b1;
          sign_q <= len_neg_q;
          idx_q  <= len_top_q;
        end
      end else if (adv) begin
        if (sign_q) begin
          sign_q <= 1'b0;
        end else if (idx_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && len_valid_q) begin
      digits_q <= len_digits_q;
    end
    if (busy_q && adv) begin
      out_char_q <= sign_q ? CHAR_MINUS : HEX_CHARS[digits_q[idx_q*DIGIT_W +: DIGIT_W]];
      out_last_q <= !sign_q && (idx_q == '0);
    end
  end

endmodule

// ===== hdl/b2a_chk.sv =====
`include "binary_to_ascii_number_formatter_macros.svh"

module b2a_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);
  import b2a_pkg::*;

  // Hold a stalled output.
  `B2A_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "output changed while stalled")

  `B2A_ASSERT(a_char_set, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
      (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h46) || m_axis_tdata == CHAR_MINUS,
    "character outside the digit set")

  `B2A_ASSERT(a_minus_not_last, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata == CHAR_MINUS |-> !m_axis_tlast,
    "minus sign marked last")

  // An edge seen in reset leaves the output idle for the next edge.
  `B2A_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    !rst_ni |=> !m_axis_tvalid,
    "output valid after reset")

endmodule

bind binary_to_ascii_number_formatter b2a_chk u_b2a_chk (.*);

// ===== tb/binary_to_ascii_number_formatter_tb.sv =====
module binary_to_ascii_number_formatter_tb;
  import b2a_pkg::*;

  typedef struct {
    mode_e       mode;
    logic [63:0] value;
    logic [1:0]  hex_width;
  } number_t;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  number_t pending_numbers[$];
  char_t   expected_chars[$];
  int      errors = 0;
  int      chars_seen = 0;
  int      numbers_sent = 0;
  int      cycles = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  bit      hold_sender = 0;

  binary_to_ascii_number_formatter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib - 4'd10);
  endfunction

  // Push the text of one number onto the expected character queue.
  function automatic void format_number(number_t n);
    logic [63:0] mag;
    logic [7:0]  digits[$];
    int          count;
    if (n.mode == MODE_HEX) begin
      count = 2 << n.hex_width;
      for (int i = count - 1; i >= 0; i--)
        expected_chars.push_back('{hex_char(n.value[i*4 +: 4]), i == 0});
    end else if (n.mode != MODE_NONE) begin
      mag = n.value;
      if (n.mode == MODE_SDEC && n.value[63]) begin
        mag = ~n.value + 64'd1;
        expected_chars.push_back('{CHAR_MINUS, 1'b0});
      end
      do begin
        digits.push_front(8'h30 + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 0);
      foreach (digits[i]) expected_chars.push_back('{digits[i], i == digits.size() - 1});
    end
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = 64'($urandom_range(0, 20));
      2: v = ~(64'($urandom_range(0, 20)));
      default: ;
    endcase
    return v;
  endfunction

  // Driver: bursts and gaps; hold-off pauses until the result queue drains.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        format_number(pending_numbers.pop_front());
        numbers_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current item
      end else if (pending_numbers.size() > 0 && !hold_sender &&
                   (s_axis_tvalid ? burst_left > 0 : gap_left == 0)) begin
        if (!s_axis_tvalid) burst_left <= $urandom_range(1, 12);
        else burst_left <= burst_left - 1;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= pending_numbers[0].value;
        s_axis_tuser  <= {pending_numbers[0].hex_width, pending_numbers[0].mode};
      end else begin
        if (s_axis_tvalid) gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
        else if (gap_left > 0) gap_left <= gap_left - 1;
        s_axis_tvalid <= 0;
      end
    end
  end

  // Receiver is ready throughout a periodic window and stalls at random outside it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= (cycles % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each character transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h", m_axis_tdata);
        errors++;
      end else begin
        char_t e;
        e = expected_chars.pop_front();
        if (m_axis_tdata !== e.character) begin
          $error("character: expected %h actual %h", e.character, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %b actual %b", e.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("binary_to_ascii_number_formatter test failed");
      $finish;
    end
  end

  task automatic add_number(mode_e m, logic [63:0] v, logic [1:0] w);
    pending_numbers.push_back('{m, v, w});
  endtask

  initial begin
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // Extremes, single digits, most negative signed value, every hex width.
    add_number(MODE_UDEC, 64'd0, 2'd0);
    add_number(MODE_UDEC, 64'd7, 2'd3);
    add_number(MODE_UDEC, 64'd10, 2'd0);
    add_number(MODE_UDEC, '1, 2'd0);
    add_number(MODE_SDEC, 64'd0, 2'd0);
    add_number(MODE_SDEC, 64'd9, 2'd0);
    add_number(MODE_SDEC, '1, 2'd0);
    add_number(MODE_SDEC, 64'h8000_0000_0000_0000, 2'd0);
    add_number(MODE_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 2'd1);
    add_number(MODE_NONE, 64'h1234, 2'd2);
    for (int w = 0; w < 4; w++) begin
      add_number(MODE_HEX, 64'h0123_4567_89AB_CDEF, 2'(w));
      add_number(MODE_HEX, '1, 2'(w));
    end
    add_number(MODE_HEX, 64'd0, 2'd3);
    add_number(MODE_NONE, '1, 2'd3);
    for (int i = 0; i < 300; i++)
      add_number(mode_e'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
                 rand64(), 2'($urandom_range(0, 3)));
    // Drain completely partway through.
    wait (numbers_sent >= 150);
    hold_sender = 1;
    wait (expected_chars.size() == 0);
    repeat (40) @(posedge clk_i);
    hold_sender = 0;
    wait (pending_numbers.size() == 0);
    wait (expected_chars.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d numbers in all modes and hex widths; checked %0d characters.",
             numbers_sent, chars_seen);
    if (errors == 0 && expected_chars.size() == 0)
      $display("binary_to_ascii_number_formatter test passed");
    else
      $display("binary_to_ascii_number_formatter test failed");
    $finish;
  end

endmodule
